### rtl/udrb_pkg.sv
// Package for the UART dual ring buffer.
// Holds the request and result beat types, request and status codes,
// the command type between front and back, and the back state encoding.
package udrb_pkg;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       line_busy;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       tx_valid;
    logic       tx_idle;
    logic       rx_overrun;
    logic [5:0] rx_count;
    logic [6:0] tx_count;
    logic [5:0] seek_pos;
  } out_t;

  localparam logic [2:0] REQ_RX_BYTE = 3'd0;
  localparam logic [2:0] REQ_TX_SLOT = 3'd1;
  localparam logic [2:0] REQ_PUSH    = 3'd2;
  localparam logic [2:0] REQ_POP     = 3'd3;
  localparam logic [2:0] REQ_SEEK    = 3'd4;
  localparam logic [2:0] REQ_FLUSH   = 3'd5;
  localparam logic [2:0] REQ_QUERY   = 3'd6;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TX_FULL  = 2'd1;
  localparam logic [1:0] STAT_RX_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_RX_BYTE,
    OP_TX_SLOT,
    OP_PUSH,
    OP_POP,
    OP_SEEK,
    OP_FLUSH,
    OP_QUERY,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       line_busy;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEEK
  } state_e;

  localparam int unsigned CMDQ_DEPTH = 2;

endpackage

### rtl/udrb_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module udrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/udrb_front.sv
// Front end: accepts request beats and classifies them into commands.
// Depends on udrb_pkg.
module udrb_front (
  input  logic          start_i,
  input  udrb_pkg::in_t req_i,
  input  logic          cmdq_full_i,
  output logic          busy_o,
  output logic          cmdq_push_o,
  output udrb_pkg::cmd_t cmdq_cmd_o
);
  import udrb_pkg::*;

  op_e op;

  always_comb begin
    case (req_i.req_type)
      REQ_RX_BYTE: op = OP_RX_BYTE;
      REQ_TX_SLOT: op = OP_TX_SLOT;
      REQ_PUSH:    op = OP_PUSH;
      REQ_POP:     op = OP_POP;
      REQ_SEEK:    op = OP_SEEK;
      REQ_FLUSH:   op = OP_FLUSH;
      REQ_QUERY:   op = OP_QUERY;
      default:     op = OP_NOP;
    endcase
  end

  assign busy_o               = cmdq_full_i;
  assign cmdq_push_o          = start_i && !cmdq_full_i;
  assign cmdq_cmd_o.op        = op;
  assign cmdq_cmd_o.data      = req_i.data_byte;
  assign cmdq_cmd_o.line_busy = req_i.line_busy;

endmodule

### rtl/udrb_cmdq.sv
// Short command queue between front and back.
// Depends on udrb_pkg.
module udrb_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  udrb_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output udrb_pkg::cmd_t cmd_o
);
  import udrb_pkg::*;

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slot_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign full_o  = (count_q == CW'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/udrb_back.sv
// Back end: executes commands on the receive and transmit rings.
// Depends on udrb_pkg and udrb_ram; registers one result beat per command.
module udrb_back #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmdq_valid_i,
  input  udrb_pkg::cmd_t cmdq_cmd_i,
  output logic           cmdq_pop_o,
  output logic           res_valid_o,
  output udrb_pkg::out_t res_o
);
  import udrb_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned EW = AW + 7;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [AW-1:0] scan_q, scan_d;
  logic          pend_q, pend_d;
  logic          res_vld_q, res_vld_d;
  out_t          res_q, res_d;

  logic          rx_we, tx_we;
  logic [AW-1:0] rx_raddr;
  logic [7:0]    rx_rdata, tx_rdata;
  logic [AW-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
  logic [AW-1:0] rx_fill_q, rx_fill_d, tx_fill_d, spos;
  logic [EW-1:0] rx_fill_x, tx_cnt_x, spos_x;
  logic          rx_nonempty, tx_nonempty, seek_hit, fin, cur_busy;
  logic [1:0]    status;
  logic [7:0]    obyte;
  logic          txv, txi, ovr;

  udrb_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (cmdq_cmd_i.data),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  udrb_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (cmdq_cmd_i.data),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  assign rx_head_inc = rx_head_q + 1'b1;
  assign rx_tail_inc = rx_tail_q + 1'b1;
  assign tx_head_inc = tx_head_q + 1'b1;
  assign tx_tail_inc = tx_tail_q + 1'b1;
  assign rx_nonempty = (rx_head_q != rx_tail_q);
  assign tx_nonempty = (tx_head_q != tx_tail_q);
  assign rx_fill_q   = rx_head_q - rx_tail_q;
  assign seek_hit    = pend_q && (rx_rdata == cmd_q.data);
  assign cur_busy    = (state_q == ST_IDLE) ? cmdq_cmd_i.line_busy : cmd_q.line_busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmdq_valid_i) begin
          case (cmdq_cmd_i.op)
            OP_TX_SLOT: if (tx_nonempty) state_d = ST_READ;
            OP_POP:     if (rx_nonempty) state_d = ST_READ;
            OP_SEEK:    state_d = ST_SEEK;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_SEEK: begin
        if (seek_hit || (scan_q == rx_fill_q)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    cmd_d      = cmd_q;
    scan_d     = scan_q;
    pend_d     = 1'b0;
    rx_we      = 1'b0;
    tx_we      = 1'b0;
    rx_raddr   = rx_tail_q;
    cmdq_pop_o = 1'b0;
    fin        = 1'b0;
    status     = STAT_OK;
    obyte      = '0;
    txv        = 1'b0;
    txi        = 1'b0;
    ovr        = 1'b0;
    spos       = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmdq_valid_i) begin
          cmdq_pop_o = 1'b1;
          cmd_d      = cmdq_cmd_i;
          scan_d     = '0;
          case (cmdq_cmd_i.op)
            OP_RX_BYTE: begin
              rx_we     = 1'b1;
              rx_head_d = rx_head_inc;
              if (rx_head_inc == rx_tail_q) begin
                rx_tail_d = rx_tail_inc;
                ovr       = 1'b1;
              end
              fin = 1'b1;
            end
            OP_TX_SLOT: begin
              if (tx_nonempty) begin
                tx_tail_d = tx_tail_inc;
              end else begin
                txi = 1'b1;
                fin = 1'b1;
              end
            end
            OP_PUSH: begin
              if (tx_head_inc == tx_tail_q) begin
                status = STAT_TX_FULL;
              end else begin
                tx_we     = 1'b1;
                tx_head_d = tx_head_inc;
              end
              fin = 1'b1;
            end
            OP_POP: begin
              if (rx_nonempty) begin
                rx_tail_d = rx_tail_inc;
              end else begin
                status = STAT_RX_EMPTY;
                fin    = 1'b1;
              end
            end
            OP_SEEK: fin = 1'b0;
            OP_FLUSH: begin
              rx_tail_d = rx_head_q;
              fin       = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        fin = 1'b1;
        if (cmd_q.op == OP_TX_SLOT) begin
          obyte = tx_rdata;
          txv   = 1'b1;
        end else begin
          obyte = rx_rdata;
        end
      end
      ST_SEEK: begin
        rx_raddr = rx_tail_q + scan_q;
        if (!seek_hit && (scan_q != rx_fill_q)) begin
          scan_d = scan_q + 1'b1;
          pend_d = 1'b1;
        end
        if (seek_hit) begin
          fin  = 1'b1;
          spos = scan_q;
        end else if (scan_q == rx_fill_q) begin
          fin = 1'b1;
        end
      end
      default: fin = 1'b0;
    endcase
  end

  assign rx_fill_d = rx_head_d - rx_tail_d;
  assign tx_fill_d = tx_head_d - tx_tail_d;
  assign rx_fill_x = {7'b0, rx_fill_d};
  assign tx_cnt_x  = {7'b0, tx_fill_d} + EW'(cur_busy);
  assign spos_x    = {7'b0, spos};

  always_comb begin
    res_vld_d        = fin;
    res_d.status     = status;
    res_d.out_byte   = obyte;
    res_d.tx_valid   = txv;
    res_d.tx_idle    = txi;
    res_d.rx_overrun = ovr;
    res_d.rx_count   = rx_fill_x[5:0];
    res_d.tx_count   = tx_cnt_x[6:0];
    res_d.seek_pos   = spos_x[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    scan_q <= scan_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

### rtl/uart_dual_ring_buffer_top.sv
// Top level of the UART dual ring buffer: receive and transmit rings.
// Depends on udrb_pkg, udrb_front, udrb_cmdq and udrb_back.
//
// Usage: drive a request beat on req_i with start high; it is taken at a
// rising edge where busy is low. Each request gives exactly one result beat
// on res_o, marked by res_valid_o for one cycle; the receiver must take it
// then, as there is no way to hold results off. Results come in request
// order.
// After acceptance, a command passes through the command queue into the back
// end. Rx byte, push, flush, query, no-op and empty-ring cases finish in the
// back's idle state; a pop or tx slot that reads a ring adds the read state; a
// seek reads one receive entry per cycle from the tail through the ring RAM's
// registered read port until a match or the end of the filled entries.
// Throughput: one single-cycle request per cycle; ring reads and seeks hold
// the back end for their full length while the two-entry command queue
// absorbs new beats, and busy rises when that queue is full.
// Reset: rings empty, queue empty, no result pending. Ring contents are not
// cleared; only written entries are ever read.
module uart_dual_ring_buffer_top #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  udrb_pkg::in_t  req_i,
  output logic           res_valid_o,
  output udrb_pkg::out_t res_o
);
  import udrb_pkg::*;

  logic cmdq_push, cmdq_full, cmdq_valid, cmdq_pop;
  cmd_t cmdq_in, cmdq_out;

  udrb_front u_front (
    .start_i     (start),
    .req_i       (req_i),
    .cmdq_full_i (cmdq_full),
    .busy_o      (busy),
    .cmdq_push_o (cmdq_push),
    .cmdq_cmd_o  (cmdq_in)
  );

  udrb_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmdq_push),
    .cmd_i   (cmdq_in),
    .pop_i   (cmdq_pop),
    .full_o  (cmdq_full),
    .valid_o (cmdq_valid),
    .cmd_o   (cmdq_out)
  );

  udrb_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmdq_valid_i (cmdq_valid),
    .cmdq_cmd_i   (cmdq_out),
    .cmdq_pop_o   (cmdq_pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  a_tx_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.tx_valid && res_o.tx_idle))
    else $error("tx_valid and tx_idle both set");

  a_empty_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == STAT_RX_EMPTY) |-> (res_o.rx_count == '0))
    else $error("empty pop with nonzero rx count");

  a_tx_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.tx_valid |-> (res_o.status == STAT_OK))
    else $error("tx dequeue with error status");

  a_seek_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.seek_pos != '0) |-> (res_o.out_byte == '0))
    else $error("seek result carries a byte");

endmodule

### dv/tb_uart_dual_ring_buffer_top.sv
// Testbench for uart_dual_ring_buffer_top: a directed table, then random traffic bursts, all
// scored against table results (typed rows) or an in-bench model of both rings.
// Depends on udrb_pkg and the RTL top level.
module tb_uart_dual_ring_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import udrb_pkg::*;

  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned RANDOM_BEATS = 1400;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned NUM_ROWS     = 25;
  localparam logic [2:0]  REQ_NONE     = 3'd7;
  localparam out_t        NO_RES       = '0;

  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t res;
  } stim_row_t;

  // status, out_byte, tx_valid, tx_idle, rx_overrun, rx_count, tx_count, seek_pos
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{REQ_QUERY,   8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_QUERY,   8'h00, 1'b1}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd1, 6'd0}},
    '{'{REQ_POP,     8'h00, 1'b0}, 1'b1,
      '{STAT_RX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_TX_SLOT, 8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_SEEK,    8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_FLUSH,   8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_NONE,    8'hFF, 1'b1}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd1, 6'd0}},
    '{'{REQ_RX_BYTE, 8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd1, 7'd0, 6'd0}},
    '{'{REQ_RX_BYTE, 8'hFF, 1'b1}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd2, 7'd1, 6'd0}},
    '{'{REQ_RX_BYTE, 8'h5A, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_SEEK,    8'hFF, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd3, 7'd0, 6'd2}},
    '{'{REQ_SEEK,    8'h77, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_SEEK,    8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd3, 7'd0, 6'd1}},
    '{'{REQ_POP,     8'hFF, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd2, 7'd0, 6'd0}},
    '{'{REQ_PUSH,    8'hFF, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_PUSH,    8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_PUSH,    8'h80, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_TX_SLOT, 8'h00, 1'b1}, 1'b1, '{STAT_OK, 8'hFF, 1'b1, 1'b0, 1'b0, 6'd2, 7'd3, 6'd0}},
    '{'{REQ_TX_SLOT, 8'hA5, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_TX_SLOT, 8'h00, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_TX_SLOT, 8'h00, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b1, 1'b0, 6'd2, 7'd0, 6'd0}},
    '{'{REQ_FLUSH,   8'h3C, 1'b0}, 1'b1, '{STAT_OK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_POP,     8'h00, 1'b0}, 1'b1,
      '{STAT_RX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0, 7'd0, 6'd0}},
    '{'{REQ_RX_BYTE, 8'h01, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_SEEK,    8'h01, 1'b0}, 1'b0, NO_RES}
  };

  localparam int unsigned IDLE_PLAN [3] = '{0, 85, 31};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  in_t  req_i  = '0;
  logic res_valid_o;
  out_t res_o;

  logic [7:0] rx_ring [RING_DEPTH];
  logic [7:0] tx_ring [RING_DEPTH];
  logic [5:0] rx_wr = '0;
  logic [5:0] rx_rd = '0;
  logic [5:0] tx_wr = '0;
  logic [5:0] tx_rd = '0;

  out_t        expected_results [$];
  out_t        oldest_res;
  int unsigned idle_pct       = 0;
  int unsigned beats_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned failures       = 0;
  int unsigned cycle_count    = 0;
  int unsigned overruns       = 0;
  int unsigned push_rejects   = 0;
  int unsigned empty_pops     = 0;
  int unsigned seek_hits      = 0;

  uart_dual_ring_buffer_top #(
    .BUFFER_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic out_t predict_ring_result(in_t beat);
    out_t       res;
    logic [5:0] rx_fill;
    res = '0;
    case (beat.req_type)
      REQ_RX_BYTE: begin
        rx_ring[rx_wr] = beat.data_byte;
        rx_wr = 6'(rx_wr + 1);
        if (rx_wr == rx_rd) begin
          rx_rd = 6'(rx_rd + 1);
          res.rx_overrun = 1'b1;
          overruns++;
        end
      end
      REQ_TX_SLOT: begin
        if (tx_wr != tx_rd) begin
          res.out_byte = tx_ring[tx_rd];
          res.tx_valid = 1'b1;
          tx_rd = 6'(tx_rd + 1);
        end else begin
          res.tx_idle = 1'b1;
        end
      end
      REQ_PUSH: begin
        if (6'(tx_wr + 1) == tx_rd) begin
          res.status = STAT_TX_FULL;
          push_rejects++;
        end else begin
          tx_ring[tx_wr] = beat.data_byte;
          tx_wr = 6'(tx_wr + 1);
        end
      end
      REQ_POP: begin
        if (rx_wr == rx_rd) begin
          res.status = STAT_RX_EMPTY;
          empty_pops++;
        end else begin
          res.out_byte = rx_ring[rx_rd];
          rx_rd = 6'(rx_rd + 1);
        end
      end
      REQ_SEEK: begin
        rx_fill = 6'(rx_wr - rx_rd);
        for (int i = 0; i < rx_fill; i++) begin
          if (rx_ring[6'(rx_rd + i)] == beat.data_byte) begin
            res.seek_pos = 6'(i + 1);
            seek_hits++;
            break;
          end
        end
      end
      REQ_FLUSH: begin
        rx_rd = rx_wr;
      end
      default: begin
      end
    endcase
    res.rx_count = 6'(rx_wr - rx_rd);
    res.tx_count = 7'(6'(tx_wr - tx_rd)) + 7'(beat.line_busy);
    return res;
  endfunction

  function automatic in_t make_beat(logic [2:0] kind, logic [7:0] data);
    in_t beat;
    beat.req_type  = kind;
    beat.data_byte = data;
    beat.line_busy = 1'($urandom);
    return beat;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Enter and leave at a falling edge; start stays high between back-to-back beats.
  task automatic send_beat(in_t beat, logic typed, out_t typed_res);
    int unsigned gap;
    out_t        predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        req_i <= in_t'(12'($urandom));
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    req_i <= beat;
    do @(posedge clk_i); while (busy);
    predicted = predict_ring_result(beat);
    expected_results.push_back(typed ? typed_res : predicted);
    beats_accepted++;
    @(negedge clk_i);
  endtask

  task automatic send_random(logic [2:0] kind, logic [7:0] data);
    send_beat(make_beat(kind, data), 1'b0, NO_RES);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %p", res_o);
        failures++;
      end else begin
        oldest_res = expected_results.pop_front();
        check_field("status",     oldest_res.status,     res_o.status);
        check_field("out_byte",   oldest_res.out_byte,   res_o.out_byte);
        check_field("tx_valid",   oldest_res.tx_valid,   res_o.tx_valid);
        check_field("tx_idle",    oldest_res.tx_idle,    res_o.tx_idle);
        check_field("rx_overrun", oldest_res.rx_overrun, res_o.rx_overrun);
        check_field("rx_count",   oldest_res.rx_count,   res_o.rx_count);
        check_field("tx_count",   oldest_res.tx_count,   res_o.tx_count);
        check_field("seek_pos",   oldest_res.seek_pos,   res_o.seek_pos);
      end
    end
  end

  initial begin
    int unsigned burst_idx;
    burst_idx = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    while (beats_accepted < NUM_ROWS + RANDOM_BEATS) begin
      idle_pct = IDLE_PLAN[burst_idx % 3];
      burst_idx++;
      case ($urandom_range(0, 3))
        0: begin
          repeat ($urandom_range(20, 40)) send_random(3'($urandom_range(0, 7)), 8'($urandom));
        end
        1: begin
          repeat ($urandom_range(58, 72)) send_random(REQ_RX_BYTE, 8'($urandom_range(0, 15)));
          repeat (4) send_random(REQ_SEEK, 8'($urandom_range(0, 20)));
          repeat ($urandom_range(0, 8)) send_random(REQ_POP, 8'($urandom));
          if ($urandom_range(0, 3) == 0) send_random(REQ_FLUSH, 8'($urandom));
        end
        2: begin
          repeat ($urandom_range(60, 68)) send_random(REQ_PUSH, 8'($urandom));
          send_random(REQ_QUERY, 8'($urandom));
          repeat ($urandom_range(0, 70)) send_random(REQ_TX_SLOT, 8'($urandom));
        end
        default: begin
          repeat ($urandom_range(4, 16)) send_random(REQ_RX_BYTE, 8'($urandom_range(0, 7)));
          repeat (8) begin
            send_random(REQ_SEEK, 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) send_random(REQ_POP, 8'($urandom));
          end
        end
      endcase
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d request beats (%0d from the table), scored %0d results.",
             beats_accepted, NUM_ROWS, results_seen);
    $display("Saw %0d rx overruns, %0d rejected pushes, %0d empty pops, %0d seek hits.",
             overruns, push_rejects, empty_pops, seek_hits);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
